// File: hw/rtl/polynomial_shift_byte_cipher_assert.svh
// Assertion macros used by the checker file.
`ifndef POLYNOMIAL_SHIFT_BYTE_CIPHER_ASSERT_SVH
`define POLYNOMIAL_SHIFT_BYTE_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PSCB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pscb assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is low.
`define PSCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pscb assertion failed: next-cycle check");

`endif

// File: hw/rtl/pscb_pkg.sv
package pscb_pkg;

    // Key polynomial shape
    localparam int NUM_TERMS = 4;
    localparam int COEF_REGS = 4;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = CFG_IDX_W'(4);

    // Queue between front and back; depth is a power of two so the pointers wrap
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Horner step counter
    localparam int STEP_W = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
    } pscb_item_t;

endpackage

// File: hw/rtl/pscb_front.sv
module pscb_front
    import pscb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_first_of_message,
    input  logic              q_full,
    output logic              q_push,
    output pscb_item_t        q_item
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] cur_pos;

    // Restart the count on a start flag, otherwise take the running position
    assign cur_pos = s_first_of_message ? '0 : pos_reg;

    assign s_ready          = !q_full;
    assign q_push           = s_valid && !q_full;
    assign q_item.data_byte = s_data_byte;
    assign q_item.position  = cur_pos;

    // Advance the position on every accepted beat
    always_comb begin
        pos_next = pos_reg;
        if (q_push) begin
            pos_next = cur_pos + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: hw/rtl/pscb_queue.sv
module pscb_queue
    import pscb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  pscb_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output pscb_item_t pop_item
);

    pscb_item_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/pscb_back.sv
module pscb_back
    import pscb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  pscb_item_t            q_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_out_byte
);

    localparam logic [STEP_W-1:0] LAST_TERM = STEP_W'(NUM_TERMS - 1);

    logic [BYTE_W-1:0]     coef_reg [COEF_REGS];
    logic                  dir_reg;

    logic                  busy_reg;
    logic                  busy_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [BYTE_W-1:0]     acc_reg;
    logic [BYTE_W-1:0]     acc_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [BYTE_W-1:0]     data_reg;
    logic [BYTE_W-1:0]     data_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic [BYTE_W-1:0]     out_byte_next;

    logic                  done;
    logic                  out_free;
    logic                  finish;
    logic [STEP_W-1:0]     sel_idx;
    logic [BYTE_W-1:0]     coef_sel;
    logic [2*BYTE_W-1:0]   prod;
    logic [BYTE_W-1:0]     result;

    assign cfg_ready  = 1'b1;
    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < COEF_REGS; j++) begin
                coef_reg[j] <= '0;
            end
            dir_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COEF_0:    coef_reg[0] <= cfg_data;
                REG_COEF_1:    coef_reg[1] <= cfg_data;
                REG_COEF_2:    coef_reg[2] <= cfg_data;
                REG_COEF_3:    coef_reg[3] <= cfg_data;
                REG_DIRECTION: dir_reg     <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign done     = busy_reg && (step_reg == '0);
    assign out_free = !out_valid_reg || m_ready;
    assign finish   = done && out_free;
    assign q_pop    = q_valid && (!busy_reg || finish);

    // Pick the coefficient for this Horner step; terms past the registers are zero
    assign sel_idx = q_pop ? LAST_TERM : (step_reg - STEP_W'(1));

    always_comb begin
        coef_sel = '0;
        for (int j = 0; j < COEF_REGS; j++) begin
            if (int'(sel_idx) == j) begin
                coef_sel = coef_reg[j];
            end
        end
    end

    assign prod   = acc_reg * pos_reg;
    assign result = dir_reg ? (data_reg - acc_reg) : (data_reg + acc_reg);

    // Load a new beat, run one multiply-add per cycle, hand off the result
    always_comb begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (finish) begin
            out_valid_next = 1'b1;
            out_byte_next  = result;
            busy_next      = 1'b0;
        end else if (busy_reg && (step_reg != '0)) begin
            acc_next  = prod[BYTE_W-1:0] + coef_sel;
            step_next = step_reg - STEP_W'(1);
        end

        if (q_pop) begin
            busy_next = 1'b1;
            step_next = LAST_TERM;
            acc_next  = coef_sel;
            pos_next  = q_item.position;
            data_next = q_item.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers hold without reset
    always_ff @(posedge aclk) begin
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        pos_reg      <= pos_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
    end

endmodule

// File: hw/rtl/polynomial_shift_byte_cipher.sv
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_data_byte[7:0], s_first_of_message
// m_        m_valid / m_ready    m_out_byte[7:0]
// cfg_      cfg_valid / cfg_ready cfg_index[2:0], cfg_data[7:0]
//
// Each byte runs the Horner key evaluation in the back end, one 8x8 multiply-add
// per cycle, and that loop sets the sustained rate. With an empty queue a beat
// passes a queue entry, the Horner steps and the output register to m_out_byte.
// aresetn is synchronous, active low; it clears the position, the key registers,
// the queue, the back end's busy flag and the output valid. cfg_ready is always high.
// A stalled m_ready holds the result; the front keeps taking beats into a
// two-entry queue and the back keeps evaluating until both are full.
module polynomial_shift_byte_cipher
    import pscb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_data_byte,
    input  logic                  s_first_of_message,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_out_byte,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic       q_full;
    logic       q_push;
    pscb_item_t q_push_item;
    logic       q_valid;
    logic       q_pop;
    pscb_item_t q_pop_item;

    pscb_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_first_of_message (s_first_of_message),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_item             (q_push_item)
    );

    pscb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_pop_item)
    );

    pscb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_pop_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte)
    );

endmodule

// File: hw/rtl/pscb_checker.sv
`include "polynomial_shift_byte_cipher_assert.svh"

module pscb_checker
    import pscb_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BYTE_W-1:0] m_out_byte
);

    // Beats held inside: queue entries, one in evaluation, one in the output register
    localparam int HELD_MAX = QUEUE_DEPTH + 2;
    localparam int HELD_W   = $clog2(HELD_MAX + 1);

    logic [HELD_W-1:0] held_reg;
    logic              in_beat;
    logic              out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // Track beats accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            case ({in_beat, out_beat})
                2'b10:   held_reg <= held_reg + HELD_W'(1);
                2'b01:   held_reg <= held_reg - HELD_W'(1);
                default: held_reg <= held_reg;
            endcase
        end
    end

    `PSCB_ASSERT_NOW(a_no_invented_result, aclk, aresetn, m_valid, held_reg != '0)
    `PSCB_ASSERT_NOW(a_full_blocks_input, aclk, aresetn, held_reg == HELD_W'(HELD_MAX), !s_ready)
    `PSCB_ASSERT_NEXT(a_out_valid_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
    `PSCB_ASSERT_NEXT(a_out_data_holds, aclk, aresetn, m_valid && !m_ready, $stable(m_out_byte))

endmodule

bind polynomial_shift_byte_cipher pscb_checker u_pscb_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte)
);

// File: sim/polynomial_shift_byte_cipher_tb.sv
`timescale 1ns / 100ps

module polynomial_shift_byte_cipher_tb;
    import pscb_pkg::*;

    localparam int DRAIN_CYCLES = 2 * NUM_TERMS + 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CFG_TOP_INDEX = (1 << CFG_IDX_W) - 1;
    localparam int COEF_SEL_W = (COEF_REGS > 1) ? $clog2(COEF_REGS) : 1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_of_message;
    } plain_beat_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_data_byte = '0;
    logic                  s_first_of_message = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BYTE_W-1:0]     m_out_byte;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the key registers and the running position
    logic [BYTE_W-1:0] key_coef [COEF_REGS];
    logic              decrypt_mode;
    logic [POS_W-1:0]  msg_position;

    plain_beat_t       pending_beats [$];
    logic [BYTE_W-1:0] expected_bytes [$];

    int  mismatch_count = 0;
    int  gap_percent = 0;
    int  stall_percent = 0;
    bit  no_idle = 1'b0;
    bit  hold_off_req = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;

    polynomial_shift_byte_cipher u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_first_of_message (s_first_of_message),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Horner evaluation of the key polynomial, 8 bits wide
    function automatic logic [BYTE_W-1:0] key_for(logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] term;
        acc = '0;
        for (int i = NUM_TERMS - 1; i >= 0; i--) begin
            term = (i < COEF_REGS) ? key_coef[i] : '0;
            acc = acc * pos + term;
        end
        return acc;
    endfunction

    // Driver: predict on each accepted beat, then offer the next one
    always @(posedge aclk) begin
        plain_beat_t       beat;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] key_val;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                pos = s_first_of_message ? '0 : msg_position;
                key_val = key_for(pos);
                expected_bytes.push_back(decrypt_mode ? s_data_byte - key_val
                                                      : s_data_byte + key_val);
                msg_position = pos + 1'b1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!no_idle && pending_beats.size() != 0 &&
                             $urandom_range(0, 99) < gap_percent) begin
                    gap_left = $urandom_range(1, 15) - 1;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    beat = pending_beats.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= beat.data_byte;
                    s_first_of_message <= beat.first_of_message;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat, then pick the next ready level
    always @(posedge aclk) begin
        logic [BYTE_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: unexpected beat, actual %02h", m_out_byte);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_out_byte !== want) begin
                        $error("out_byte: expected %02h actual %02h", want, m_out_byte);
                        mismatch_count++;
                    end
                end
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < stall_percent) begin
                stall_left = $urandom_range(1, 15) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < COEF_REGS) begin
            key_coef[idx[COEF_SEL_W-1:0]] = val;
        end else if (idx == REG_DIRECTION) begin
            decrypt_mode = val[0];
        end
    endtask

    // Load all key registers, with one stray write to an unused index first
    task automatic program_key(input logic [7:0] c0, input logic [7:0] c1,
                               input logic [7:0] c2, input logic [7:0] c3,
                               input logic [7:0] dir_byte);
        write_reg(CFG_IDX_W'($urandom_range(REG_DIRECTION + 1, CFG_TOP_INDEX)),
                  CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_COEF_0, c0);
        write_reg(REG_COEF_1, c1);
        write_reg(REG_COEF_2, c2);
        write_reg(REG_COEF_3, c3);
        write_reg(REG_DIRECTION, dir_byte);
        @(negedge aclk);
    endtask

    task automatic program_random_key();
        program_key(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic first);
        plain_beat_t b;
        b.data_byte = data;
        b.first_of_message = first;
        pending_beats.push_back(b);
    endtask

    // One message: start flag on the first byte, some flags scrambled as noise
    task automatic queue_message(input int len, input int noise_pct);
        plain_beat_t b;
        for (int n = 0; n < len; n++) begin
            b.data_byte = BYTE_W'($urandom_range(0, 255));
            b.first_of_message = (n == 0);
            if ($urandom_range(0, 99) < noise_pct) b.first_of_message = 1'($urandom_range(0, 1));
            pending_beats.push_back(b);
        end
    endtask

    task automatic queue_messages(input int total, input int noise_pct);
        int count;
        int len;
        count = 0;
        while (count < total) begin
            len = $urandom_range(1, 24);
            queue_message(len, noise_pct);
            count += len;
        end
    endtask

    // Wait until the block is empty, then let the pipeline settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        for (int i = 0; i < COEF_REGS; i++) key_coef[i] = '0;
        decrypt_mode = 1'b0;
        msg_position = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset key, no start flag on the very first byte
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h5A, 1'b1);
        queue_byte(8'hA5, 1'b0);
        wait_drained();

        // Largest coefficients, decrypt
        program_key(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h7F, 1'b1);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'h00, 1'b0);
        wait_drained();

        // Cubic term only, encrypt with the upper data bits set
        program_key(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFE);
        queue_byte(8'hAA, 1'b1);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h33, 1'b1);
        queue_byte(8'hCC, 1'b0);
        queue_byte(8'h0F, 1'b1);
        queue_byte(8'hF0, 1'b0);
        wait_drained();

        // Random traffic with idling on both sides
        gap_percent = 20;
        stall_percent = 20;
        program_random_key();
        queue_messages(90, 10);
        wait_drained();

        // Long message past the position wrap, with a long receiver hold-off
        gap_percent = 5;
        stall_percent = 10;
        program_random_key();
        hold_off_req = 1'b1;
        queue_message(280, 0);
        queue_messages(20, 10);
        wait_drained();

        // Heavy back-pressure, zero key then random
        gap_percent = 5;
        stall_percent = 50;
        program_key(8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
        queue_messages(30, 10);
        wait_drained();
        program_random_key();
        queue_messages(60, 15);
        wait_drained();

        // Closing stretch at full rate
        no_idle = 1'b1;
        program_random_key();
        queue_messages(50, 10);
        wait_drained();

        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("polynomial_shift_byte_cipher_tb: done, clean");
        end else begin
            $display("polynomial_shift_byte_cipher_tb: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("polynomial_shift_byte_cipher_tb: done, errors");
        $finish;
    end

endmodule
